>>> rtl/istsq_pkg.sv
// Package for the I2C status transfer sequencer.
// Holds function codes, controller status codes, control masks and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package istsq_pkg;

    localparam logic [2:0] FN_STATUS = 3'd0;
    localparam logic [2:0] FN_BUF_WR = 3'd1;
    localparam logic [2:0] FN_BUF_RD = 3'd2;
    localparam logic [2:0] FN_TX     = 3'd3;
    localparam logic [2:0] FN_RX     = 3'd4;

    localparam logic [7:0] ST_BUS_ERR         = 8'h00;
    localparam logic [7:0] ST_START           = 8'h08;
    localparam logic [7:0] ST_RSTART          = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK      = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK     = 8'h20;
    localparam logic [7:0] ST_MT_DATA_ACK     = 8'h28;
    localparam logic [7:0] ST_MT_DATA_NACK    = 8'h30;
    localparam logic [7:0] ST_ARB_LOST        = 8'h38;
    localparam logic [7:0] ST_MR_SLA_ACK      = 8'h40;
    localparam logic [7:0] ST_MR_SLA_NACK     = 8'h48;
    localparam logic [7:0] ST_MR_DATA_ACK     = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK    = 8'h58;
    localparam logic [7:0] ST_SR_SLA_ACK      = 8'h60;
    localparam logic [7:0] ST_SR_ARB_SLA      = 8'h68;
    localparam logic [7:0] ST_SR_GC_ACK       = 8'h70;
    localparam logic [7:0] ST_SR_ARB_GC       = 8'h78;
    localparam logic [7:0] ST_SR_DATA_ACK     = 8'h80;
    localparam logic [7:0] ST_SR_DATA_NACK    = 8'h88;
    localparam logic [7:0] ST_SR_GC_DATA_ACK  = 8'h90;
    localparam logic [7:0] ST_SR_GC_DATA_NACK = 8'h98;
    localparam logic [7:0] ST_SR_STOP         = 8'hA0;
    localparam logic [7:0] ST_ST_SLA_ACK      = 8'hA8;
    localparam logic [7:0] ST_ST_ARB_SLA      = 8'hB0;
    localparam logic [7:0] ST_ST_DATA_ACK     = 8'hB8;
    localparam logic [7:0] ST_ST_DATA_NACK    = 8'hC0;
    localparam logic [7:0] ST_ST_LAST_ACK     = 8'hC8;
    localparam logic [7:0] ST_IDLE            = 8'hF8;

    localparam logic [6:0] M_AA  = 7'h04;
    localparam logic [6:0] M_SI  = 7'h08;
    localparam logic [6:0] M_STO = 7'h10;
    localparam logic [6:0] M_STA = 7'h20;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] status_code;
        logic [7:0] data_byte;
        logic [8:0] buffer_index;
        logic [7:0] target_addr;
        logic [9:0] transfer_count;
    } item_t;

    typedef struct packed {
        logic       write_dat;
        logic       dat_mem;
        logic [7:0] dat_const;
        logic [6:0] con_clear;
        logic [6:0] con_set;
        logic       start_request;
        logic       busy;
        logic       err;
        logic [9:0] data_count;
        logic       rd_mem;
        logic       mem_ok;
    } res_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

>>> rtl/istsq_mem.sv
// Byte store: one write port and one read port with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module istsq_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] byte_store_reg [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            byte_store_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= byte_store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/istsq_ctrl.sv
// Transfer state and status-code decode: computes one result per item and the
// store access for it. Depends on istsq_pkg.
`timescale 1ns / 1ps

module istsq_ctrl #(
    parameter int BUFFER_DEPTH = 512,
    parameter int AW           = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  istsq_pkg::item_t   item,
    input  logic               cfg_we,
    input  logic [9:0]         cfg_wdata,
    output istsq_pkg::res_t    res,
    output istsq_pkg::mem_ctl_t mem_ctl,
    output logic [AW-1:0]      mem_waddr,
    output logic [7:0]         mem_wdata,
    output logic [AW-1:0]      mem_raddr
);

    localparam int CW  = $clog2(BUFFER_DEPTH + 1);
    localparam int XW  = ((CW > 10) ? CW : 10) + 1;
    localparam logic [XW-1:0] DEPTH_X = XW'(BUFFER_DEPTH);

    logic [CW-1:0] send_index_reg, send_index_next;
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic          busy_reg, busy_next;
    logic          error_reg, error_next;
    logic [7:0]    slave_addr_reg, slave_addr_next;
    logic [9:0]    exp_rx_reg;

    logic [XW-1:0] si_x, si_adv, bc_x, exp_x, raddr_x, waddr_x, si_new, bc_after;
    logic          recv_ok, rx_last;

    assign si_x    = XW'(send_index_reg);
    assign bc_x    = XW'(byte_count_reg);
    assign exp_x   = XW'(exp_rx_reg);
    assign si_adv  = (si_x < DEPTH_X) ? si_x + XW'(1) : si_x;
    assign recv_ok = bc_x < DEPTH_X;
    assign rx_last = (bc_x + XW'(1)) == exp_x;

    always_comb
    begin
        res             = '0;
        mem_ctl         = '0;
        raddr_x         = '0;
        waddr_x         = bc_x;
        mem_wdata       = item.data_byte;
        si_new          = si_x;
        bc_after        = bc_x;
        send_index_next = send_index_reg;
        byte_count_next = byte_count_reg;
        busy_next       = busy_reg;
        error_next      = error_reg;
        slave_addr_next = slave_addr_reg;

        case (item.func)
            istsq_pkg::FN_STATUS:
            begin
                case (item.status_code)
                    istsq_pkg::ST_START, istsq_pkg::ST_RSTART:
                    begin
                        res.write_dat   = 1'b1;
                        res.dat_const   = slave_addr_reg;
                        res.con_clear   = istsq_pkg::M_STO | istsq_pkg::M_SI;
                        send_index_next = '0;
                    end
                    istsq_pkg::ST_MT_SLA_ACK:
                    begin
                        res.write_dat = 1'b1;
                        res.dat_mem   = 1'b1;
                        mem_ctl.re    = 1'b1;
                        raddr_x       = si_x;
                        res.con_clear = istsq_pkg::M_STA | istsq_pkg::M_STO | istsq_pkg::M_SI;
                    end
                    istsq_pkg::ST_MT_SLA_NACK, istsq_pkg::ST_MT_DATA_NACK,
                    istsq_pkg::ST_MR_SLA_NACK:
                    begin
                        res.con_clear = istsq_pkg::M_STA | istsq_pkg::M_SI;
                        res.con_set   = istsq_pkg::M_STO;
                        error_next    = 1'b1;
                        busy_next     = 1'b0;
                    end
                    istsq_pkg::ST_MT_DATA_ACK:
                    begin
                        send_index_next = CW'(si_adv);
                        if (si_adv < bc_x)
                        begin
                            res.write_dat = 1'b1;
                            res.dat_mem   = 1'b1;
                            mem_ctl.re    = 1'b1;
                            raddr_x       = si_adv;
                            res.con_clear = istsq_pkg::M_STA | istsq_pkg::M_STO
                                            | istsq_pkg::M_SI;
                        end
                        else
                        begin
                            res.con_clear = istsq_pkg::M_STA | istsq_pkg::M_SI;
                            res.con_set   = istsq_pkg::M_STO;
                            busy_next     = 1'b0;
                        end
                    end
                    istsq_pkg::ST_ARB_LOST:
                    begin
                        res.con_clear = istsq_pkg::M_STA | istsq_pkg::M_STO | istsq_pkg::M_SI;
                        error_next    = 1'b1;
                        busy_next     = 1'b0;
                    end
                    istsq_pkg::ST_MR_SLA_ACK:
                    begin
                        byte_count_next = '0;
                        res.con_clear   = istsq_pkg::M_STA | istsq_pkg::M_STO
                                          | istsq_pkg::M_SI;
                        if (exp_rx_reg == 10'd1)
                        begin
                            res.con_clear = res.con_clear | istsq_pkg::M_AA;
                        end
                        else
                        begin
                            res.con_set = istsq_pkg::M_AA;
                        end
                    end
                    istsq_pkg::ST_MR_DATA_ACK:
                    begin
                        if (recv_ok)
                        begin
                            mem_ctl.we = 1'b1;
                            bc_after   = bc_x + XW'(1);
                        end
                        else
                        begin
                            error_next = 1'b1;
                        end
                        byte_count_next = CW'(bc_after);
                        if ((bc_after + XW'(1)) == exp_x)
                        begin
                            res.con_clear = istsq_pkg::M_STA | istsq_pkg::M_STO
                                            | istsq_pkg::M_SI | istsq_pkg::M_AA;
                        end
                        else
                        begin
                            res.con_clear = istsq_pkg::M_STA | istsq_pkg::M_STO
                                            | istsq_pkg::M_SI;
                            res.con_set   = istsq_pkg::M_AA;
                        end
                    end
                    istsq_pkg::ST_MR_DATA_NACK:
                    begin
                        if (rx_last)
                        begin
                            if (recv_ok)
                            begin
                                mem_ctl.we = 1'b1;
                                bc_after   = bc_x + XW'(1);
                            end
                            else
                            begin
                                error_next = 1'b1;
                            end
                        end
                        byte_count_next = CW'(bc_after);
                        res.con_clear   = istsq_pkg::M_STA | istsq_pkg::M_SI;
                        res.con_set     = istsq_pkg::M_STO;
                        if (bc_after < exp_x)
                        begin
                            error_next = 1'b1;
                        end
                        busy_next = 1'b0;
                    end
                    istsq_pkg::ST_SR_SLA_ACK, istsq_pkg::ST_SR_GC_ACK:
                    begin
                        res.con_clear   = istsq_pkg::M_STO | istsq_pkg::M_SI;
                        res.con_set     = istsq_pkg::M_AA;
                        byte_count_next = '0;
                    end
                    istsq_pkg::ST_SR_ARB_SLA, istsq_pkg::ST_SR_ARB_GC:
                    begin
                        res.con_clear = istsq_pkg::M_STO | istsq_pkg::M_SI | istsq_pkg::M_AA;
                        error_next    = 1'b1;
                    end
                    istsq_pkg::ST_SR_DATA_ACK, istsq_pkg::ST_SR_GC_DATA_ACK:
                    begin
                        if (recv_ok)
                        begin
                            mem_ctl.we      = 1'b1;
                            byte_count_next = CW'(bc_x + XW'(1));
                        end
                        else
                        begin
                            error_next = 1'b1;
                        end
                        res.con_clear = istsq_pkg::M_STO | istsq_pkg::M_SI;
                        res.con_set   = istsq_pkg::M_AA;
                    end
                    istsq_pkg::ST_SR_DATA_NACK, istsq_pkg::ST_SR_GC_DATA_NACK:
                    begin
                        res.con_clear = istsq_pkg::M_STA | istsq_pkg::M_STO | istsq_pkg::M_SI;
                        res.con_set   = istsq_pkg::M_AA;
                        error_next    = 1'b1;
                    end
                    istsq_pkg::ST_SR_STOP:
                    begin
                        res.con_clear = istsq_pkg::M_STA | istsq_pkg::M_STO
                                        | istsq_pkg::M_SI | istsq_pkg::M_AA;
                        busy_next     = 1'b0;
                    end
                    istsq_pkg::ST_ST_SLA_ACK, istsq_pkg::ST_ST_ARB_SLA,
                    istsq_pkg::ST_ST_DATA_ACK:
                    begin
                        si_new = (item.status_code == istsq_pkg::ST_ST_DATA_ACK) ? si_adv
                                                                                 : '0;
                        send_index_next = CW'(si_new);
                        res.write_dat   = 1'b1;
                        res.dat_mem     = 1'b1;
                        mem_ctl.re      = 1'b1;
                        raddr_x         = si_new;
                        if (bc_x == (si_new + XW'(1)))
                        begin
                            res.con_clear = istsq_pkg::M_STO | istsq_pkg::M_SI
                                            | istsq_pkg::M_AA;
                        end
                        else
                        begin
                            res.con_clear = istsq_pkg::M_STO | istsq_pkg::M_SI;
                            res.con_set   = istsq_pkg::M_AA;
                        end
                        if (item.status_code == istsq_pkg::ST_ST_ARB_SLA)
                        begin
                            error_next = 1'b1;
                        end
                    end
                    istsq_pkg::ST_ST_DATA_NACK:
                    begin
                        if ((si_x + XW'(1)) < bc_x)
                        begin
                            error_next = 1'b1;
                        end
                        res.con_clear = istsq_pkg::M_STA | istsq_pkg::M_STO | istsq_pkg::M_SI;
                        res.con_set   = istsq_pkg::M_AA;
                        busy_next     = 1'b0;
                    end
                    istsq_pkg::ST_ST_LAST_ACK:
                    begin
                        res.con_clear = istsq_pkg::M_STA | istsq_pkg::M_STO | istsq_pkg::M_SI;
                        res.con_set   = istsq_pkg::M_AA;
                        busy_next     = 1'b0;
                    end
                    istsq_pkg::ST_IDLE:
                    begin
                        res.con_clear = '0;
                    end
                    istsq_pkg::ST_BUS_ERR:
                    begin
                        error_next    = 1'b1;
                        busy_next     = 1'b0;
                        res.con_set   = istsq_pkg::M_STO;
                        res.con_clear = istsq_pkg::M_SI;
                    end
                    default:
                    begin
                        res.con_clear = istsq_pkg::M_SI;
                        error_next    = 1'b1;
                        busy_next     = 1'b0;
                    end
                endcase
            end
            istsq_pkg::FN_BUF_WR:
            begin
                waddr_x = XW'(item.buffer_index);
                if (XW'(item.buffer_index) < DEPTH_X)
                begin
                    mem_ctl.we = 1'b1;
                end
                else
                begin
                    error_next = 1'b1;
                end
            end
            istsq_pkg::FN_BUF_RD:
            begin
                res.rd_mem = 1'b1;
                mem_ctl.re = 1'b1;
                raddr_x    = XW'(item.buffer_index);
            end
            istsq_pkg::FN_TX:
            begin
                slave_addr_next = item.target_addr;
                byte_count_next = (XW'(item.transfer_count) > DEPTH_X)
                                  ? CW'(BUFFER_DEPTH) : CW'(item.transfer_count);
                error_next        = 1'b0;
                busy_next         = 1'b1;
                res.start_request = 1'b1;
            end
            istsq_pkg::FN_RX:
            begin
                error_next        = 1'b0;
                busy_next         = 1'b1;
                res.start_request = 1'b1;
            end
            default:
            begin
                res.start_request = 1'b0;
            end
        endcase

        res.mem_ok     = raddr_x < DEPTH_X;
        res.busy       = busy_next;
        res.err        = error_next;
        res.data_count = 10'(byte_count_next);
    end

    assign mem_raddr = raddr_x[AW-1:0];
    assign mem_waddr = waddr_x[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_index_reg <= '0;
            byte_count_reg <= '0;
            busy_reg       <= 1'b0;
            error_reg      <= 1'b0;
            slave_addr_reg <= '0;
        end
        else if (step)
        begin
            send_index_reg <= send_index_next;
            byte_count_reg <= byte_count_next;
            busy_reg       <= busy_next;
            error_reg      <= error_next;
            slave_addr_reg <= slave_addr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_rx_reg <= 10'd1;
        end
        else if (cfg_we)
        begin
            exp_rx_reg <= cfg_wdata;
        end
    end

endmodule

>>> rtl/i2c_status_transfer_sequencer_top.sv
// Throughput: 1 item per cycle while out_ready does not stall the result register.
// Stage 1 is the input register; stage 2 decodes, updates state, accesses the
// byte store and loads the result register together with the store read data.
// Reset (rst_n, async, active low) clears counters, flags, slave address and
// sets expected_rx_count to 1; the byte store itself is not cleared.
// Top level of the I2C status transfer sequencer.
// Depends on istsq_pkg, istsq_ctrl and istsq_mem.
`timescale 1ns / 1ps

module i2c_status_transfer_sequencer_top #(
    parameter int BUFFER_DEPTH = 512
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] func,
    input  logic [7:0] status_code,
    input  logic [7:0] data_byte,
    input  logic [8:0] buffer_index,
    input  logic [7:0] target_addr,
    input  logic [9:0] transfer_count,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       write_dat,
    output logic [7:0] dat_value,
    output logic [6:0] con_clear,
    output logic [6:0] con_set,
    output logic       start_request,
    output logic       busy_res,
    output logic       error,
    output logic [9:0] data_count,
    output logic [7:0] read_data,
    input  logic       cfg_we,
    input  logic [9:0] cfg_wdata
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic                in_valid_reg;
    istsq_pkg::item_t    item_reg;
    logic                out_valid_reg;
    istsq_pkg::res_t     res_reg;
    istsq_pkg::res_t     res_comb;
    istsq_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [7:0]          mem_wdata, mem_rdata, mem_byte;
    logic                adv, step;

    assign adv      = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && adv;
    assign in_ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{func, status_code, data_byte, buffer_index, target_addr,
                          transfer_count};
        end
        if (step)
        begin
            res_reg <= res_comb;
        end
    end

    istsq_ctrl #(
        .BUFFER_DEPTH(BUFFER_DEPTH),
        .AW(AW)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .item(item_reg),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .res(res_comb),
        .mem_ctl(mem_ctl),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_raddr(mem_raddr)
    );

    istsq_mem #(
        .DEPTH(BUFFER_DEPTH),
        .AW(AW)
    ) u_mem (
        .clk(clk),
        .we(step && mem_ctl.we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re(step && mem_ctl.re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign mem_byte      = res_reg.mem_ok ? mem_rdata : 8'h00;
    assign out_valid     = out_valid_reg;
    assign write_dat     = res_reg.write_dat;
    assign dat_value     = res_reg.dat_mem ? mem_byte : res_reg.dat_const;
    assign con_clear     = res_reg.con_clear;
    assign con_set       = res_reg.con_set;
    assign start_request = res_reg.start_request;
    assign busy_res      = res_reg.busy;
    assign error         = res_reg.err;
    assign data_count    = res_reg.data_count;
    assign read_data     = res_reg.rd_mem ? mem_byte : 8'h00;

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_request |-> busy_res && !error)
        else $error("start request without busy or with error");

    a_no_dat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_dat |-> dat_value == 8'h00)
        else $error("data byte driven without load");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(data_count) <= 32'(BUFFER_DEPTH)))
        else $error("byte count above buffer depth");

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("processed item did not reach the result register");

endmodule
